/* src/pfde_pkg.sv */
// ----------------------------------------------------------------------------
// pfde_pkg
// Shared types and constants of the page framebuffer draw engine.
// ----------------------------------------------------------------------------
package pfde_pkg;

  // Command codes of the input channel.
  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_PIXEL = 3'd1;
  localparam logic [2:0] CMD_RECT  = 3'd2;
  localparam logic [2:0] CMD_FILL  = 3'd3;
  localparam logic [2:0] CMD_FLUSH = 3'd4;

  // Result item kinds.
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  // Controller address command bases.
  localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
  localparam logic [7:0] COL_LO_BASE   = 8'h00;
  localparam logic [7:0] COL_HI_BASE   = 8'h10;
  localparam logic [7:0] NIBBLE_MASK   = 8'h0F;

  localparam logic [7:0] COL_OFFSET_RESET = 8'd2;

  // One store row holds eight column bytes of a page.
  localparam int WORD_W = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAN,
    ST_WRITE,
    ST_FL_HDR,
    ST_FLUSH
  } pfde_state_t;

  typedef enum logic [1:0] {
    M_PIXEL,
    M_OUTLINE,
    M_FILL
  } draw_mode_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear_all;
  } store_ctl_t;

endpackage

/* src/pfde_if.sv */
// ----------------------------------------------------------------------------
// pfde_if
// Valid/ready channels of the draw engine: command input and result output.
// ----------------------------------------------------------------------------
interface pfde_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [7:0] rect_width;
  logic [7:0] rect_height;
  logic       ink;
  logic [2:0] page_select;

  modport source (
    output valid, command, pos_x, pos_y, rect_width, rect_height, ink, page_select,
    input  ready
  );
  modport sink (
    input  valid, command, pos_x, pos_y, rect_width, rect_height, ink, page_select,
    output ready
  );
endinterface

interface pfde_res_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  page_command;
  logic [7:0]  column_low_command;
  logic [7:0]  column_high_command;
  logic [63:0] pixel_bytes;
  logic        last;

  modport source (
    output valid, item_kind, page_command, column_low_command, column_high_command,
           pixel_bytes, last,
    input  ready
  );
  modport sink (
    input  valid, item_kind, page_command, column_low_command, column_high_command,
           pixel_bytes, last,
    output ready
  );
endinterface

/* src/pfde_store.sv */
// ----------------------------------------------------------------------------
// pfde_store
// Frame store: one row per eight columns of a page, with a row valid bit so
// that a clear resets every row at once. Read data is registered.
// ----------------------------------------------------------------------------
module pfde_store #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pfde_pkg::store_ctl_t         ctl,
  input  logic [ADDR_W-1:0]            rd_addr,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [pfde_pkg::WORD_W-1:0]  wr_data,
  output logic [pfde_pkg::WORD_W-1:0]  rd_data
);

  logic [pfde_pkg::WORD_W-1:0] mem [DEPTH];
  logic [pfde_pkg::WORD_W-1:0] rdata_r;
  logic [DEPTH-1:0]            valid_r;
  logic                        rd_valid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // A row that was never written since the last clear reads as all zeros.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctl.clear_all) begin
        valid_r <= '0;
      end else if (ctl.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rdata_r : '0;

endmodule

/* src/page_framebuffer_draw_engine.sv */
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine
// Monochrome page framebuffer with pixel, rectangle outline, filled rectangle,
// clear and page flush.
// Clear resets every row valid bit at once. Each on-screen pixel is a
// read-modify-write of one store row (read in ST_SPAN, written in ST_WRITE); an off-screen pixel is skipped.
// A flush gives its header from ST_FL_HDR once the output register is free, then one
// data beat per cycle while the sink is ready: 1 + (DISPLAY_WIDTH+7)/8 beats.
// The single store read port sets the drawing rate. Reset clears all row valid
// bits at once, so the store reads as zero right after reset with no sweep.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine #(
  parameter int DISPLAY_WIDTH = 128,
  parameter int DISPLAY_PAGES = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  pfde_cmd_if.sink   in_ch,
  pfde_res_if.source out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  localparam int WPP    = (DISPLAY_WIDTH + 7) / 8;
  localparam int DEPTH  = DISPLAY_PAGES * WPP;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HEIGHT = 8 * DISPLAY_PAGES;
  localparam int WC_W   = $clog2(WPP + 1);

  pfde_pkg::pfde_state_t state_r, state_nxt;
  pfde_pkg::draw_mode_t  mode_r, mode_nxt;

  logic [7:0]      x_r, x_nxt, y_r, y_nxt, w_r, w_nxt, h_r, h_nxt;
  logic            ink_r, ink_nxt;
  logic [2:0]      page_r, page_nxt;
  logic [1:0]      seg_r, seg_nxt;
  logic [7:0]      row_r, row_nxt, step_r, step_nxt;
  logic [WC_W-1:0] rd_wd_r, rd_wd_nxt;
  logic            pend_r, pend_nxt, pend_last_r, pend_last_nxt;
  logic [7:0]      col_off_r;

  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [7:0]  out_pg_r, out_pg_nxt, out_lo_r, out_lo_nxt, out_hi_r, out_hi_nxt;
  logic [63:0] out_bytes_r, out_bytes_nxt;
  logic        out_last_r, out_last_nxt;

  pfde_pkg::store_ctl_t          st_ctl;
  logic [AW-1:0]                 rd_addr, draw_addr, flush_addr;
  logic [pfde_pkg::WORD_W-1:0]   rd_word, mod_word;

  logic [7:0] px, py, span_len;
  logic       on_screen, out_free, load_data, issue;

  pfde_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (st_ctl),
    .rd_addr (rd_addr),
    .wr_addr (draw_addr),
    .wr_data (mod_word),
    .rd_data (rd_word)
  );

  // Current pixel of the span walk. Segments 0 and 1 are the top and bottom
  // edges of an outline, 2 and 3 the left and right edges.
  always_comb begin
    px       = x_r;
    py       = y_r;
    span_len = 8'd1;
    unique case (mode_r)
      pfde_pkg::M_FILL: begin
        px       = 8'(x_r + step_r);
        py       = 8'(y_r + row_r);
        span_len = w_r;
      end
      pfde_pkg::M_OUTLINE: begin
        unique case (seg_r)
          2'd0: begin
            px       = 8'(x_r + step_r);
            py       = y_r;
            span_len = w_r;
          end
          2'd1: begin
            px       = 8'(x_r + step_r);
            py       = 8'(y_r + h_r - 8'd1);
            span_len = w_r;
          end
          2'd2: begin
            px       = x_r;
            py       = 8'(y_r + step_r);
            span_len = h_r;
          end
          default: begin
            px       = 8'(x_r + w_r - 8'd1);
            py       = 8'(y_r + step_r);
            span_len = h_r;
          end
        endcase
      end
      default: begin
        px       = x_r;
        py       = y_r;
        span_len = 8'd1;
      end
    endcase
  end

  assign on_screen  = (px < 8'(DISPLAY_WIDTH)) && (py < 8'(HEIGHT));
  assign draw_addr  = AW'(16'(py[5:3]) * 16'(WPP) + 16'(px[7:3]));
  assign flush_addr = AW'(16'(page_r) * 16'(WPP) + 16'(rd_wd_r));
  assign rd_addr    = (state_r == pfde_pkg::ST_SPAN) ? draw_addr : flush_addr;

  always_comb begin
    mod_word = rd_word;
    mod_word[{px[2:0], py[2:0]}] = ink_r;
  end

  assign in_ch.ready = (state_r == pfde_pkg::ST_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign load_data   = pend_r && out_free && (state_r == pfde_pkg::ST_FLUSH);
  assign issue       = ((state_r == pfde_pkg::ST_FL_HDR) || (state_r == pfde_pkg::ST_FLUSH))
                       && (rd_wd_r != WC_W'(WPP)) && (!pend_r || load_data);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    ink_nxt       = ink_r;
    page_nxt      = page_r;
    seg_nxt       = seg_r;
    row_nxt       = row_r;
    step_nxt      = step_r;
    rd_wd_nxt     = rd_wd_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_pg_nxt    = out_pg_r;
    out_lo_nxt    = out_lo_r;
    out_hi_nxt    = out_hi_r;
    out_bytes_nxt = out_bytes_r;
    out_last_nxt  = out_last_r;
    st_ctl        = '0;

    unique case (state_r)
      pfde_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          x_nxt    = in_ch.pos_x;
          y_nxt    = in_ch.pos_y;
          w_nxt    = in_ch.rect_width;
          h_nxt    = in_ch.rect_height;
          ink_nxt  = in_ch.ink;
          page_nxt = in_ch.page_select;
          seg_nxt  = 2'd0;
          row_nxt  = 8'd0;
          step_nxt = 8'd0;
          unique case (in_ch.command)
            pfde_pkg::CMD_CLEAR: st_ctl.clear_all = 1'b1;
            pfde_pkg::CMD_PIXEL: begin
              mode_nxt  = pfde_pkg::M_PIXEL;
              state_nxt = pfde_pkg::ST_SPAN;
            end
            pfde_pkg::CMD_RECT: begin
              mode_nxt  = pfde_pkg::M_OUTLINE;
              state_nxt = pfde_pkg::ST_SPAN;
            end
            pfde_pkg::CMD_FILL: begin
              mode_nxt  = pfde_pkg::M_FILL;
              state_nxt = pfde_pkg::ST_SPAN;
            end
            pfde_pkg::CMD_FLUSH: begin
              if (4'(in_ch.page_select) < 4'(DISPLAY_PAGES)) begin
                rd_wd_nxt = '0;
                state_nxt = pfde_pkg::ST_FL_HDR;
              end
            end
            default: ;
          endcase
        end
      end

      pfde_pkg::ST_SPAN: begin
        priority if ((mode_r == pfde_pkg::M_FILL) && (row_r == h_r)) begin
          state_nxt = pfde_pkg::ST_IDLE;
        end else if (step_r == span_len) begin
          step_nxt = 8'd0;
          unique case (mode_r)
            pfde_pkg::M_OUTLINE: begin
              if (seg_r == 2'd3) begin
                state_nxt = pfde_pkg::ST_IDLE;
              end else begin
                seg_nxt = seg_r + 2'd1;
              end
            end
            pfde_pkg::M_FILL: row_nxt = row_r + 8'd1;
            default: state_nxt = pfde_pkg::ST_IDLE;
          endcase
        end else if (on_screen) begin
          st_ctl.rd_en = 1'b1;
          state_nxt    = pfde_pkg::ST_WRITE;
        end else begin
          step_nxt = step_r + 8'd1;
        end
      end

      pfde_pkg::ST_WRITE: begin
        // Pixel coordinates still match the row read in the previous cycle.
        st_ctl.wr_en = 1'b1;
        step_nxt     = step_r + 8'd1;
        state_nxt    = pfde_pkg::ST_SPAN;
      end

      pfde_pkg::ST_FL_HDR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = pfde_pkg::KIND_HEADER;
          out_pg_nxt    = pfde_pkg::PAGE_CMD_BASE + 8'(page_r);
          out_lo_nxt    = pfde_pkg::COL_LO_BASE + (col_off_r & pfde_pkg::NIBBLE_MASK);
          out_hi_nxt    = pfde_pkg::COL_HI_BASE + {4'd0, col_off_r[7:4]};
          out_bytes_nxt = '0;
          out_last_nxt  = 1'b0;
          state_nxt     = pfde_pkg::ST_FLUSH;
        end
      end

      default: ;
    endcase

    // Flush stream: store read data waits in the store read register (flagged by pend_r)
    // until the output register is free, so reads overlap a stalled beat.
    if (load_data) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = pfde_pkg::KIND_DATA;
      out_pg_nxt    = '0;
      out_lo_nxt    = '0;
      out_hi_nxt    = '0;
      out_bytes_nxt = rd_word;
      out_last_nxt  = pend_last_r;
    end
    if (issue) begin
      st_ctl.rd_en  = 1'b1;
      rd_wd_nxt     = rd_wd_r + WC_W'(1);
      pend_nxt      = 1'b1;
      pend_last_nxt = (rd_wd_r == WC_W'(WPP - 1));
    end else if (load_data) begin
      pend_nxt = 1'b0;
    end
    if ((state_r == pfde_pkg::ST_FLUSH) && (rd_wd_nxt == WC_W'(WPP)) && !pend_nxt) begin
      state_nxt = pfde_pkg::ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfde_pkg::ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      col_off_r   <= pfde_pkg::COL_OFFSET_RESET;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        col_off_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    w_r         <= w_nxt;
    h_r         <= h_nxt;
    ink_r       <= ink_nxt;
    page_r      <= page_nxt;
    seg_r       <= seg_nxt;
    row_r       <= row_nxt;
    step_r      <= step_nxt;
    rd_wd_r     <= rd_wd_nxt;
    pend_last_r <= pend_last_nxt;
    out_kind_r  <= out_kind_nxt;
    out_pg_r    <= out_pg_nxt;
    out_lo_r    <= out_lo_nxt;
    out_hi_r    <= out_hi_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.item_kind           = out_kind_r;
  assign out_ch.page_command        = out_pg_r;
  assign out_ch.column_low_command  = out_lo_r;
  assign out_ch.column_high_command = out_hi_r;
  assign out_ch.pixel_bytes         = out_bytes_r;
  assign out_ch.last                = out_last_r;

  // The store is written only in the second half of a pixel update.
  a_write_in_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    st_ctl.wr_en |-> (state_r == pfde_pkg::ST_WRITE))
    else $error("store write outside a pixel update");

  // No flush read data may be left behind when new commands are taken.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pfde_pkg::ST_IDLE) |-> !pend_r)
    else $error("flush data pending while idle");

  // Once the last data beat is loaded, the flush has finished.
  a_last_ends_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (state_r != pfde_pkg::ST_FLUSH))
    else $error("flush still running after last beat");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page framebuffer draw engine. A directed table
// covers reset contents, screen-sized fills, clipping, coordinate wrap,
// degenerate rectangles, ignored commands and column offset extremes. A
// random phase follows, with random idle and stall cycles on both channels.
// A local frame model predicts the flush beats of all but the typed directed rows,
// which give their own. Each result beat is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCREEN_W        = 128;
  localparam int SCREEN_PAGES    = 8;
  localparam int SCREEN_ROWS     = SCREEN_PAGES * 8;
  localparam int WORDS_PER_FLUSH = (SCREEN_W + 7) / 8;

  localparam logic [2:0] CMD_RSVD_LO = 3'd5;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;

  localparam int RANDOM_ITEMS = 390;
  localparam int CFG_EVERY    = 70;
  localparam int CFG_SETTLE   = 4;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_MAX   = 10;
  localparam int BIG_FILLS    = 3;
  localparam int RUN_LIMIT    = 2000000;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] width;
    logic [7:0] height;
    logic       ink;
    logic [2:0] page;
  } draw_cmd_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  page_cmd;
    logic [7:0]  col_lo;
    logic [7:0]  col_hi;
    logic [63:0] bytes;
    logic        last;
  } page_beat_t;

  // A typed row carries its flush header and one byte repeated over every
  // data word of the page.
  typedef struct packed {
    logic       is_cfg;
    logic [7:0] cfg_value;
    draw_cmd_t  cmd;
    logic       typed;
    logic [7:0] hdr_page;
    logic [7:0] hdr_col_lo;
    logic [7:0] hdr_col_hi;
    logic [7:0] fill_byte;
  } dir_row_t;

  localparam dir_row_t DIRECTED [27] = '{
    '{1'b0, 8'd0, '{pfde_pkg::CMD_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0},
      1'b1, 8'hB0, 8'h02, 8'h10, 8'h00},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1, 3'd0},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd7},
      1'b1, 8'hB7, 8'h02, 8'h10, 8'hFF},
    '{1'b1, 8'd0, '{pfde_pkg::CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd4},
      1'b1, 8'hB4, 8'h00, 8'h10, 8'hFF},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd2},
      1'b1, 8'hB2, 8'h00, 8'h10, 8'h00},
    '{1'b1, 8'd131, '{pfde_pkg::CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0},
      1'b1, 8'hB0, 8'h03, 8'h18, 8'h00},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_PIXEL, 8'd127, 8'd63, 8'd0, 8'd0, 1'b1, 3'd0},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 3'd0},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_PIXEL, 8'd128, 8'd5, 8'd0, 8'd0, 1'b1, 3'd0},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_PIXEL, 8'd5, 8'd64, 8'd0, 8'd0, 1'b1, 3'd0},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_PIXEL, 8'd255, 8'd255, 8'd0, 8'd0, 1'b1, 3'd0},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd7},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_RECT, 8'd3, 8'd2, 8'd0, 8'd5, 1'b1, 3'd0},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_RECT, 8'd10, 8'd0, 8'd6, 8'd0, 1'b1, 3'd0},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_RECT, 8'd250, 8'd60, 8'd20, 8'd10, 1'b1, 3'd0},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_RECT, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 3'd0},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_FILL, 8'd20, 8'd8, 8'd0, 8'd9, 1'b1, 3'd0},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_FILL, 8'd20, 8'd8, 8'd9, 8'd0, 1'b1, 3'd0},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_FILL, 8'd96, 8'd30, 8'd40, 8'd20, 1'b1, 3'd0},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, '{CMD_RSVD_HI, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 3'd7},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{1'b1, 8'd255, '{pfde_pkg::CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00},
    '{1'b0, 8'd0, '{pfde_pkg::CMD_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd7},
      1'b0, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  pfde_cmd_if cmd_ch ();
  pfde_res_if res_ch ();

  page_framebuffer_draw_engine #(
    .DISPLAY_WIDTH(SCREEN_W),
    .DISPLAY_PAGES(SCREEN_PAGES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (cmd_ch),
    .out_ch   (res_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Local copy of the frame and of the column offset register.
  logic [7:0]  frame_model [SCREEN_W * SCREEN_PAGES];
  logic [7:0]  col_offset_model;
  page_beat_t  pending_flush_beats [$];

  int          mismatch_count  = 0;
  int unsigned cycle_count     = 0;
  int          big_fills_left  = BIG_FILLS;
  bit          cmd_no_idle     = 1'b0;
  bit          res_no_stall    = 1'b0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Coordinates wrap modulo 256 before clipping to the visible area.
  function automatic void plot_model(int unsigned x, int unsigned y, logic ink);
    int unsigned xx;
    int unsigned yy;
    xx = x & 32'hFF;
    yy = y & 32'hFF;
    if (xx >= SCREEN_W || yy >= SCREEN_ROWS) return;
    frame_model[(yy >> 3) * SCREEN_W + xx][yy & 7] = ink;
  endfunction

  function automatic void apply_to_frame_model(draw_cmd_t c);
    page_beat_t  beat;
    logic [63:0] word;
    int unsigned col;
    case (c.command)
      pfde_pkg::CMD_CLEAR: begin
        foreach (frame_model[i]) frame_model[i] = 8'h00;
      end
      pfde_pkg::CMD_PIXEL: begin
        plot_model(c.pos_x, c.pos_y, c.ink);
      end
      pfde_pkg::CMD_RECT: begin
        for (int i = 0; i < c.width; i++) begin
          plot_model(c.pos_x + i, c.pos_y, c.ink);
          plot_model(c.pos_x + i, c.pos_y + c.height + 255, c.ink);
        end
        for (int j = 0; j < c.height; j++) begin
          plot_model(c.pos_x, c.pos_y + j, c.ink);
          plot_model(c.pos_x + c.width + 255, c.pos_y + j, c.ink);
        end
      end
      pfde_pkg::CMD_FILL: begin
        for (int i = 0; i < c.width; i++)
          for (int j = 0; j < c.height; j++)
            plot_model(c.pos_x + i, c.pos_y + j, c.ink);
      end
      pfde_pkg::CMD_FLUSH: begin
        if (c.page < SCREEN_PAGES) begin
          beat = '{pfde_pkg::KIND_HEADER, pfde_pkg::PAGE_CMD_BASE + 8'(c.page),
                   pfde_pkg::COL_LO_BASE + (col_offset_model & pfde_pkg::NIBBLE_MASK),
                   pfde_pkg::COL_HI_BASE +
                     ((col_offset_model >> 4) & pfde_pkg::NIBBLE_MASK),
                   64'h0, 1'b0};
          pending_flush_beats.push_back(beat);
          for (int wd = 0; wd < WORDS_PER_FLUSH; wd++) begin
            word = '0;
            for (int b = 0; b < 8; b++) begin
              col = wd * 8 + b;
              if (col < SCREEN_W) word[8 * b +: 8] = frame_model[c.page * SCREEN_W + col];
            end
            beat = '{pfde_pkg::KIND_DATA, 8'h00, 8'h00, 8'h00, word,
                     wd == WORDS_PER_FLUSH - 1};
            pending_flush_beats.push_back(beat);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] pick_coord(int unsigned visible);
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, visible - 1));
  endfunction

  // Fills stay small apart from at most BIG_FILLS full-range ones.
  function automatic draw_cmd_t random_command();
    draw_cmd_t   c;
    int unsigned pick;
    pick     = $urandom_range(0, 99);
    c.pos_x  = pick_coord(SCREEN_W);
    c.pos_y  = pick_coord(SCREEN_ROWS);
    c.width  = 8'($urandom_range(0, 15));
    c.height = 8'($urandom_range(0, 15));
    c.ink    = ($urandom_range(0, 9) < 7);
    c.page   = 3'($urandom_range(0, 7));
    if (pick < 4) begin
      c.command = pfde_pkg::CMD_CLEAR;
    end else if (pick < 32) begin
      c.command = pfde_pkg::CMD_PIXEL;
    end else if (pick < 50) begin
      c.command = pfde_pkg::CMD_RECT;
      if ($urandom_range(0, 1) == 1) begin
        c.width  = 8'($urandom_range(0, 255));
        c.height = 8'($urandom_range(0, 255));
      end
    end else if (pick < 68) begin
      c.command = pfde_pkg::CMD_FILL;
      if (big_fills_left > 0 && $urandom_range(0, 29) == 0) begin
        big_fills_left--;
        c.width  = 8'($urandom_range(0, 255));
        c.height = 8'($urandom_range(0, 255));
      end
    end else if (pick < 95) begin
      c.command = pfde_pkg::CMD_FLUSH;
    end else begin
      c.command = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
    end
    return c;
  endfunction

  // Called at a rising edge; returns at the edge where the beat is accepted,
  // with valid still high so that a back-to-back beat needs no second update.
  task automatic drive_command(draw_cmd_t c);
    int unsigned gap;
    if ($urandom_range(0, 24) == 0) cmd_no_idle = ($urandom_range(0, 2) == 0);
    gap = cmd_no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.command     <= c.command;
    cmd_ch.pos_x       <= c.pos_x;
    cmd_ch.pos_y       <= c.pos_y;
    cmd_ch.rect_width  <= c.width;
    cmd_ch.rect_height <= c.height;
    cmd_ch.ink         <= c.ink;
    cmd_ch.page_select <= c.page;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
  endtask

  // Drawing commands give no beats, so a flush is sent first: once its last
  // beat is out, every earlier command has finished and the engine is idle.
  task automatic write_column_offset(logic [7:0] value);
    draw_cmd_t sync_flush;
    sync_flush = '{pfde_pkg::CMD_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0,
                   3'($urandom_range(0, 7))};
    drive_command(sync_flush);
    apply_to_frame_model(sync_flush);
    cmd_ch.valid <= 1'b0;
    while (pending_flush_beats.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    col_offset_model = value;
  endtask

  initial begin
    dir_row_t    row;
    draw_cmd_t   c;
    page_beat_t  beat;
    int          n_done;
    int          next_cfg;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= 8'h00;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.command     <= pfde_pkg::CMD_CLEAR;
    cmd_ch.pos_x       <= 8'h00;
    cmd_ch.pos_y       <= 8'h00;
    cmd_ch.rect_width  <= 8'h00;
    cmd_ch.rect_height <= 8'h00;
    cmd_ch.ink         <= 1'b0;
    cmd_ch.page_select <= 3'd0;
    foreach (frame_model[i]) frame_model[i] = 8'h00;
    col_offset_model = pfde_pkg::COL_OFFSET_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      if (row.is_cfg) begin
        write_column_offset(row.cfg_value);
      end else begin
        drive_command(row.cmd);
        if (row.typed) begin
          beat = '{pfde_pkg::KIND_HEADER, row.hdr_page, row.hdr_col_lo, row.hdr_col_hi,
                   64'h0, 1'b0};
          pending_flush_beats.push_back(beat);
          for (int k = 0; k < WORDS_PER_FLUSH; k++) begin
            beat = '{pfde_pkg::KIND_DATA, 8'h00, 8'h00, 8'h00, {8{row.fill_byte}},
                     k == WORDS_PER_FLUSH - 1};
            pending_flush_beats.push_back(beat);
          end
        end else begin
          apply_to_frame_model(row.cmd);
        end
      end
    end

    n_done   = 0;
    next_cfg = CFG_EVERY;
    while (n_done < RANDOM_ITEMS) begin
      if (n_done == next_cfg) begin
        case ($urandom_range(0, 4))
          0:       write_column_offset(8'd0);
          1:       write_column_offset(8'd131);
          2:       write_column_offset(8'd255);
          3:       write_column_offset(8'($urandom_range(0, 255)));
          default: write_column_offset(8'($urandom_range(0, 131)));
        endcase
        next_cfg += CFG_EVERY;
      end
      c = random_command();
      drive_command(c);
      apply_to_frame_model(c);
      n_done++;
    end

    // A closing flush makes the last drawing commands visible to the checker.
    c = '{pfde_pkg::CMD_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'($urandom_range(0, 7))};
    drive_command(c);
    apply_to_frame_model(c);
    cmd_ch.valid <= 1'b0;

    while (pending_flush_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Result side: random stall before each beat, then compare with the oldest
  // expected beat.
  initial begin
    page_beat_t  got;
    page_beat_t  want;
    int unsigned stall;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) res_no_stall = ($urandom_range(0, 2) == 0);
      stall = res_no_stall ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      got = '{res_ch.item_kind, res_ch.page_command, res_ch.column_low_command,
              res_ch.column_high_command, res_ch.pixel_bytes, res_ch.last};
      if (pending_flush_beats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("%0t: beat with nothing expected: kind=%0d page=%h lo=%h hi=%h bytes=%h last=%0d",
                   $realtime, got.kind, got.page_cmd, got.col_lo, got.col_hi, got.bytes,
                   got.last);
      end else begin
        want = pending_flush_beats.pop_front();
        if (got.kind !== want.kind || got.page_cmd !== want.page_cmd ||
            got.col_lo !== want.col_lo || got.col_hi !== want.col_hi ||
            got.bytes !== want.bytes || got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("%0t: beat mismatch", $realtime);
            $display("  expected kind=%0d page=%h lo=%h hi=%h bytes=%h last=%0d",
                     want.kind, want.page_cmd, want.col_lo, want.col_hi, want.bytes,
                     want.last);
            $display("  actual   kind=%0d page=%h lo=%h hi=%h bytes=%h last=%0d",
                     got.kind, got.page_cmd, got.col_lo, got.col_hi, got.bytes, got.last);
          end
        end
      end
    end
  end

endmodule

/* filelist.f */
src/pfde_pkg.sv
src/pfde_if.sv
src/pfde_store.sv
src/page_framebuffer_draw_engine.sv
tb/tb_top.sv
